// File: hw/rtl/snwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snwa_pkg;

	// default sizes of the pixel map and the window
	localparam int DEF_MAX_WIDTH     = 128;
	localparam int DEF_MAX_HEIGHT    = 128;
	localparam int DEF_SEARCH_RADIUS = 6;
	localparam int DEF_RANDOM_LEVELS = 64;

	// field widths
	localparam int OP_W     = 2;
	localparam int POS_W    = 7;
	localparam int COLOR_W  = 8;
	localparam int RAND_W   = 6;
	localparam int RAND_N   = 64;
	localparam int CRD_W    = 8;
	localparam int CFG_W    = 8;
	localparam int PIX_W    = 1 + 3 * COLOR_W;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 32;
	localparam int STEP_W   = $clog2(COLOR_W);
	localparam int CH_W     = 2;
	localparam int REG_IDX_W = 1;

	// register reset values
	localparam logic [CFG_W-1:0] MAP_WIDTH_RST  = 8'd128;
	localparam logic [CFG_W-1:0] MAP_HEIGHT_RST = 8'd128;

	// item kinds
	localparam logic [OP_W-1:0] OP_SET   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

	// color channels for the shared divider
	localparam logic [CH_W-1:0] CH_RED   = 2'd0;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

	// commands from the controller to the datapath
	typedef struct packed {
		logic            load;
		logic            clr_wr;
		logic            mem_wr;
		logic            win_init;
		logic            scan_rd;
		logic            div_load;
		logic            div_step;
		logic            div_store;
		logic            out_load;
		logic [CH_W-1:0] ch;
	} snwa_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic            clr_last;
		logic            in_range;
		logic [OP_W-1:0] op;
		logic            win_last;
		logic            cnt_zero;
		logic            out_free;
	} snwa_stat_t;

	// residues of every random value, built by counting
	function automatic logic [RAND_N-1:0][RAND_W-1:0] rand_mod_table(input int levels);
		logic [RAND_N-1:0][RAND_W-1:0] tab;
		int r;
		int i;
		r = 0;
		for (i = 0; i < RAND_N; i++) begin
			tab[i] = RAND_W'(r);
			r = r + 1;
			if (r >= levels) begin
				r = 0;
			end
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/snwa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module snwa_ctrl
	import snwa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire snwa_stat_t stat,
	output snwa_cmd_t       cmd
);

	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_DECODE   = 4'd2;
	localparam logic [3:0] ST_SCAN     = 4'd3;
	localparam logic [3:0] ST_DRAIN    = 4'd4;
	localparam logic [3:0] ST_DIVLOAD  = 4'd5;
	localparam logic [3:0] ST_DIVSTEP  = 4'd6;
	localparam logic [3:0] ST_DIVSTORE = 4'd7;
	localparam logic [3:0] ST_FINISH   = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [CH_W-1:0]   ch_q, ch_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.ch  = ch_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (stat.in_range) begin
					case (stat.op)
						OP_SET, OP_CLEAR: begin
							cmd.mem_wr = 1'b1;
						end
						OP_QUERY: begin
							cmd.win_init = 1'b1;
							state_d      = ST_SCAN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.win_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ch_d    = CH_RED;
				state_d = ST_DIVLOAD;
			end
			ST_DIVLOAD: begin
				if (stat.cnt_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_load = 1'b1;
					step_d       = '0;
					state_d      = ST_DIVSTEP;
				end
			end
			ST_DIVSTEP: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_W'(COLOR_W - 1)) begin
					state_d = ST_DIVSTORE;
				end
			end
			ST_DIVSTORE: begin
				cmd.div_store = 1'b1;
				if (ch_q == CH_BLUE) begin
					state_d = ST_FINISH;
				end else begin
					ch_d    = ch_q + 1'b1;
					state_d = ST_DIVLOAD;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
			ch_q    <= CH_RED;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			ch_q    <= ch_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/snwa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module snwa_datapath
	import snwa_pkg::*;
#(
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
	parameter int SEARCH_RADIUS = DEF_SEARCH_RADIUS,
	parameter int RANDOM_LEVELS = DEF_RANDOM_LEVELS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire snwa_cmd_t        cmd,
	output snwa_stat_t            stat,
	input  wire logic [CFG_W-1:0] map_width,
	input  wire logic [CFG_W-1:0] map_height,
	input  wire logic [IN_W-1:0]  in_data,
	input  wire logic [OP_W-1:0]  in_user,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [OUT_W-1:0]      out_data,
	output logic                  out_user
);

	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIN_MAX = (2 * SEARCH_RADIUS + 1) * (2 * SEARCH_RADIUS + 1);
	localparam int CNT_W   = $clog2(WIN_MAX + 1);
	localparam int SUM_W   = CNT_W + COLOR_W;
	localparam logic [RAND_N-1:0][RAND_W-1:0] RandModTab = rand_mod_table(RANDOM_LEVELS);

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [COLOR_W-1:0] red_in_q, green_in_q, blue_in_q;
	logic [RAND_W-1:0]  rand_red_q, rand_green_q, rand_blue_q;

	// window and scan registers
	logic [CRD_W-1:0] x_q, y_q, x1_q, y0_q, y1_q;
	logic [AW-1:0]    clr_addr_q;
	logic             rd_valid_s1;
	logic [PIX_W-1:0] mem_rd_q;
	logic [PIX_W-1:0] mem [DEPTH];

	// accumulators, divider and results
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   red_sum_q, green_sum_q, blue_sum_q;
	logic [SUM_W-1:0]   rem_q, div_q, sum_sel;
	logic [COLOR_W-1:0] quo_q, red_avg_q, green_avg_q, blue_avg_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_user_q;

	logic [CRD_W-1:0] w_eff, h_eff, px_ext, py_ext, x_hi, y_hi;
	logic [CRD_W-1:0] x0_d, x1_d, y0_d, y1_d;
	logic [AW-1:0]    pix_addr, scan_addr, waddr;
	logic [PIX_W-1:0] wdata;
	logic             mem_we;
	logic             div_ge;
	logic [COLOR_W-1:0] cnt_sat;

	// map size in effect, held within one and the maximum
	always_comb begin
		if (map_width == '0) begin
			w_eff = CRD_W'(1);
		end else if ({24'd0, map_width} > 32'(MAX_WIDTH)) begin
			w_eff = CRD_W'(MAX_WIDTH);
		end else begin
			w_eff = map_width;
		end
		if (map_height == '0) begin
			h_eff = CRD_W'(1);
		end else if ({24'd0, map_height} > 32'(MAX_HEIGHT)) begin
			h_eff = CRD_W'(MAX_HEIGHT);
		end else begin
			h_eff = map_height;
		end
	end

	// clipped window bounds
	assign px_ext = {1'b0, px_q};
	assign py_ext = {1'b0, py_q};
	assign x_hi   = px_ext + CRD_W'(SEARCH_RADIUS);
	assign y_hi   = py_ext + CRD_W'(SEARCH_RADIUS);
	assign x0_d   = (px_ext > CRD_W'(SEARCH_RADIUS)) ? px_ext - CRD_W'(SEARCH_RADIUS) : '0;
	assign y0_d   = (py_ext > CRD_W'(SEARCH_RADIUS)) ? py_ext - CRD_W'(SEARCH_RADIUS) : '0;
	assign x1_d   = (x_hi >= w_eff) ? w_eff - 1'b1 : x_hi;
	assign y1_d   = (y_hi >= h_eff) ? h_eff - 1'b1 : y_hi;

	// status to the controller
	assign stat.clr_last = (clr_addr_q == AW'(DEPTH - 1));
	assign stat.in_range = (px_ext < w_eff) && (py_ext < h_eff);
	assign stat.op       = op_q;
	assign stat.win_last = (x_q == x1_q) && (y_q == y1_q);
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= in_user;
			px_q         <= in_data[6:0];
			py_q         <= in_data[13:7];
			red_in_q     <= in_data[21:14];
			green_in_q   <= in_data[29:22];
			blue_in_q    <= in_data[37:30];
			rand_red_q   <= in_data[43:38];
			rand_green_q <= in_data[49:44];
			rand_blue_q  <= in_data[55:50];
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// pixel store, one write and one registered read port
	assign pix_addr  = AW'(32'(px_q) * MAX_HEIGHT + 32'(py_q));
	assign scan_addr = AW'(32'(x_q) * MAX_HEIGHT + 32'(y_q));
	assign mem_we    = cmd.clr_wr || cmd.mem_wr;
	assign waddr     = cmd.clr_wr ? clr_addr_q : pix_addr;
	assign wdata     = (!cmd.clr_wr && op_q == OP_SET) ?
		{1'b1, red_in_q, green_in_q, blue_in_q} : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.scan_rd) begin
			mem_rd_q <= mem[scan_addr];
		end
	end

	// window walk, column inner
	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			x_q  <= x0_d;
			x1_q <= x1_d;
			y_q  <= y0_d;
			y0_q <= y0_d;
			y1_q <= y1_d;
		end else if (cmd.scan_rd) begin
			if (y_q == y1_q) begin
				y_q <= y0_q;
				x_q <= x_q + 1'b1;
			end else begin
				y_q <= y_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
		end
	end

	// count and sums of set pixels
	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			cnt_q       <= '0;
			red_sum_q   <= '0;
			green_sum_q <= '0;
			blue_sum_q  <= '0;
		end else if (rd_valid_s1 && mem_rd_q[PIX_W-1]) begin
			cnt_q       <= cnt_q + 1'b1;
			red_sum_q   <= red_sum_q + SUM_W'(mem_rd_q[23:16]);
			green_sum_q <= green_sum_q + SUM_W'(mem_rd_q[15:8]);
			blue_sum_q  <= blue_sum_q + SUM_W'(mem_rd_q[7:0]);
		end
	end

	// shared restoring divider, one quotient bit a step
	always_comb begin
		case (cmd.ch)
			CH_RED:   sum_sel = red_sum_q;
			CH_GREEN: sum_sel = green_sum_q;
			default:  sum_sel = blue_sum_q;
		endcase
	end

	assign div_ge = (rem_q >= div_q);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= sum_sel + SUM_W'(cnt_q >> 1);
			div_q <= SUM_W'(cnt_q) << (COLOR_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (div_ge) begin
				rem_q <= rem_q - div_q;
			end
			div_q <= div_q >> 1;
			quo_q <= {quo_q[COLOR_W-2:0], div_ge};
		end
		if (cmd.div_store) begin
			case (cmd.ch)
				CH_RED:   red_avg_q   <= quo_q;
				CH_GREEN: green_avg_q <= quo_q;
				default:  blue_avg_q  <= quo_q;
			endcase
		end
	end

	// result register
	assign cnt_sat = (32'(cnt_q) > 32'({COLOR_W{1'b1}})) ? {COLOR_W{1'b1}} : COLOR_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cnt_q == '0) begin
				out_data_q <= {8'd0,
					{(COLOR_W - RAND_W){1'b0}}, RandModTab[rand_blue_q],
					{(COLOR_W - RAND_W){1'b0}}, RandModTab[rand_green_q],
					{(COLOR_W - RAND_W){1'b0}}, RandModTab[rand_red_q]};
				out_user_q <= 1'b1;
			end else begin
				out_data_q <= {cnt_sat, blue_avg_q, green_avg_q, red_avg_q};
				out_user_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

`default_nettype wire

// File: hw/rtl/set_neighbor_window_average.sv
// Masked box-filter average over a pixel store of set flags and RGB colors.
// Set and clear items write one pixel; a query averages the colors of set
// pixels in the square window around its coordinate, clipped to the map size
// in the map_width and map_height registers, and returns one result item
// (fallback random color when the window holds no set pixel). Items outside
// the map are dropped without a result. After reset a clearing pass writes
// every store entry, MAX_WIDTH * MAX_HEIGHT of them (16384 by default),
// before the first item is taken; register writes are accepted throughout.
// A set, clear or dropped item is taken in the idle state and written or
// dropped in the decode state. A query walks the P pixels of the clipped
// window (169 at most by default): the store has one read port and is walked
// one pixel a cycle, then one shared divider produces 8 quotient bits per
// channel for the three channels. A query whose window holds no set pixel
// skips the divider. Either kind of query waits in its finish state while an
// earlier result still sits unaccepted in the output register. A finished
// result waits in the output register while set and clear items go on.
`timescale 1ns / 1ps
`default_nettype none

module set_neighbor_window_average
	import snwa_pkg::*;
#(
	parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
	parameter int SEARCH_RADIUS = DEF_SEARCH_RADIUS,
	parameter int RANDOM_LEVELS = DEF_RANDOM_LEVELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pos_x[6:0] pos_y[13:7] red_in[21:14] green_in[29:22] blue_in[37:30]
	// rand_red[43:38] rand_green[49:44] rand_blue[55:50]
	input  wire logic [55:0] s_tdata,
	// op[1:0]
	input  wire logic [1:0]  s_tuser,
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// red_out[7:0] green_out[15:8] blue_out[23:16] neighbor_count[31:24]
	output logic [31:0]      m_tdata,
	// used_random[0]
	output logic [0:0]       m_tuser,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CFG_W-1:0]     map_width_q, map_height_q;
	logic [REG_IDX_W-1:0] reg_idx;
	snwa_cmd_t            cmd;
	snwa_stat_t           stat;
	logic                 out_user;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAP_WIDTH_RST;
			map_height_q <= MAP_HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[CFG_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[CFG_W-1:0];
				default:        map_width_q  <= map_width_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAP_WIDTH:  prdata = {24'd0, map_width_q};
			REG_MAP_HEIGHT: prdata = {24'd0, map_height_q};
			default:        prdata = '0;
		endcase
	end

	snwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	snwa_datapath #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.SEARCH_RADIUS (SEARCH_RADIUS),
		.RANDOM_LEVELS (RANDOM_LEVELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.map_width  (map_width_q),
		.map_height (map_height_q),
		.in_data    (s_tdata),
		.in_user    (s_tuser),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata),
		.out_user   (out_user)
	);

	assign m_tuser = out_user;

	// an accepted item is decoded before the next one is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken in the cycle after an accepted item");

	// the result register is loaded only when it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

	// random fallback goes with a zero count and only then
	a_random_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tdata[31:24] == 8'd0)))
		else $error("used_random disagrees with neighbor_count");

endmodule

`default_nettype wire

// File: tb/set_neighbor_window_average_tb.sv
`timescale 1ns / 1ps

module set_neighbor_window_average_tb;
	import snwa_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int MAP_DIM       = 128;
	localparam int RADIUS        = 6;
	localparam int LEVELS        = 64;
	localparam int QUERY_CYCLES  = 4 + 169 + 30;
	localparam int SETTLE_CYCLES = QUERY_CYCLES + 16;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [RAND_W-1:0]  rand_red;
		logic [RAND_W-1:0]  rand_green;
		logic [RAND_W-1:0]  rand_blue;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] count;
		logic       used_random;
	} avg_color_t;

	// mirror of the pixel store, window averaging and the queue of expected colors
	class window_avg_board;
		bit          pix_set [MAP_DIM*MAP_DIM];
		logic [23:0] pix_rgb [MAP_DIM*MAP_DIM];
		logic [7:0]  width_reg;
		logic [7:0]  height_reg;
		avg_color_t  pending_colors [$];
		int          failures;

		function new();
			foreach (pix_set[i]) begin
				pix_set[i] = 1'b0;
				pix_rgb[i] = '0;
			end
			width_reg  = MAP_WIDTH_RST;
			height_reg = MAP_HEIGHT_RST;
			failures   = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
			if (idx == REG_MAP_WIDTH) begin
				width_reg = value[7:0];
			end else begin
				height_reg = value[7:0];
			end
		endfunction

		// size in effect: register held within 1..MAP_DIM
		function int clamp_size(logic [7:0] v);
			if (v == 8'd0) return 1;
			if (int'(v) > MAP_DIM) return MAP_DIM;
			return int'(v);
		endfunction

		function void note_item(pixel_item_t it);
			int w, h, px, py, idx;
			int x0, x1, y0, y1, xi, yi;
			int n, rs, gs, bs;
			avg_color_t c;
			w  = clamp_size(width_reg);
			h  = clamp_size(height_reg);
			px = int'(it.pos_x);
			py = int'(it.pos_y);
			// items off the map are dropped
			if (px >= w || py >= h) return;
			idx = px * MAP_DIM + py;
			case (it.op)
				OP_SET: begin
					pix_set[idx] = 1'b1;
					pix_rgb[idx] = {it.red, it.green, it.blue};
				end
				OP_CLEAR: begin
					pix_set[idx] = 1'b0;
					pix_rgb[idx] = '0;
				end
				OP_QUERY: begin
					x0 = (px > RADIUS) ? px - RADIUS : 0;
					y0 = (py > RADIUS) ? py - RADIUS : 0;
					x1 = (px + RADIUS >= w) ? w - 1 : px + RADIUS;
					y1 = (py + RADIUS >= h) ? h - 1 : py + RADIUS;
					n  = 0;
					rs = 0;
					gs = 0;
					bs = 0;
					for (xi = x0; xi <= x1; xi++) begin
						for (yi = y0; yi <= y1; yi++) begin
							if (pix_set[xi*MAP_DIM+yi]) begin
								n++;
								rs += pix_rgb[xi*MAP_DIM+yi][23:16];
								gs += pix_rgb[xi*MAP_DIM+yi][15:8];
								bs += pix_rgb[xi*MAP_DIM+yi][7:0];
							end
						end
					end
					if (n == 0) begin
						// empty window falls back to the supplied random color
						c.red         = 8'(int'(it.rand_red) % LEVELS);
						c.green       = 8'(int'(it.rand_green) % LEVELS);
						c.blue        = 8'(int'(it.rand_blue) % LEVELS);
						c.count       = 8'd0;
						c.used_random = 1'b1;
					end else begin
						c.red         = 8'((rs + n / 2) / n);
						c.green       = 8'((gs + n / 2) / n);
						c.blue        = 8'((bs + n / 2) / n);
						c.count       = (n > 255) ? 8'd255 : 8'(n);
						c.used_random = 1'b0;
					end
					pending_colors.push_back(c);
				end
				default: ;
			endcase
		endfunction

		function void check_color(logic [31:0] data, logic [0:0] user);
			avg_color_t e;
			if (pending_colors.size() == 0) begin
				$error("result item with no query waiting: data %h user %b", data, user);
				failures++;
				return;
			end
			e = pending_colors.pop_front();
			if (data[7:0] !== e.red) begin
				$error("red_out: expected %0d, actual %0d", e.red, data[7:0]);
				failures++;
			end
			if (data[15:8] !== e.green) begin
				$error("green_out: expected %0d, actual %0d", e.green, data[15:8]);
				failures++;
			end
			if (data[23:16] !== e.blue) begin
				$error("blue_out: expected %0d, actual %0d", e.blue, data[23:16]);
				failures++;
			end
			if (data[31:24] !== e.count) begin
				$error("neighbor_count: expected %0d, actual %0d", e.count, data[31:24]);
				failures++;
			end
			if (user[0] !== e.used_random) begin
				$error("used_random: expected %0d, actual %0d", e.used_random, user[0]);
				failures++;
			end
		endfunction

		function int waiting();
			return pending_colors.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// pos_x pos_y red_in green_in blue_in rand_red rand_green rand_blue
	logic [55:0] s_tdata  = '0;
	// op
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// red_out green_out blue_out neighbor_count
	logic [31:0] m_tdata;
	// used_random
	logic [0:0]  m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	window_avg_board board;
	bit              quiet = 1'b0;

	set_neighbor_window_average u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("set_neighbor_window_average_tb failed");
		$finish;
	end

	// idle length: mostly none or short, a few long
	function int pick_gap();
		int p;
		if (quiet) return 0;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function int clip_coord(int v, int size);
		if (v < 0) return 0;
		if (v >= size) return size - 1;
		return v;
	endfunction

	// result side back-pressure
	initial begin
		int run;
		int gap;
		forever begin
			run = $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_color(m_tdata, m_tuser);
		end
	end

	task send_item(input pixel_item_t it);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {it.rand_blue, it.rand_green, it.rand_red,
			it.blue, it.green, it.red, it.pos_y, it.pos_x};
		do @(posedge clk); while (!s_tready);
		board.note_item(it);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task put(input logic [OP_W-1:0] op, input int x, input int y,
		input int r, input int g, input int b,
		input int rr, input int rg, input int rb);
		pixel_item_t it;
		it.op         = op;
		it.pos_x      = POS_W'(x);
		it.pos_y      = POS_W'(y);
		it.red        = COLOR_W'(r);
		it.green      = COLOR_W'(g);
		it.blue       = COLOR_W'(b);
		it.rand_red   = RAND_W'(rr);
		it.rand_green = RAND_W'(rg);
		it.rand_blue  = RAND_W'(rb);
		send_item(it);
	endtask

	task put_random(input logic [OP_W-1:0] op, input int x, input int y);
		put(op, x, y, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	task apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stop offering items, wait for all queries to report, then let set or
	// clear items finish
	task drain();
		s_tvalid <= 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_map(input int w, input int h);
		drain();
		apb_write(REG_MAP_WIDTH, 32'(w));
		apb_write(REG_MAP_HEIGHT, 32'(h));
	endtask

	// random traffic around a moving hot spot so windows find neighbors
	task run_phase(input int w_reg, input int h_reg, input int target);
		int w, h, cx, cy, x, y, pick, done;
		logic [OP_W-1:0] op;
		set_map(w_reg, h_reg);
		w     = board.clamp_size(8'(w_reg));
		h     = board.clamp_size(8'(h_reg));
		quiet = ($urandom_range(0, 3) == 0);
		cx    = $urandom_range(0, w - 1);
		cy    = $urandom_range(0, h - 1);
		done  = 0;
		while (done < target) begin
			if ($urandom_range(0, 29) == 0) begin
				cx = $urandom_range(0, w - 1);
				cy = $urandom_range(0, h - 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) op = OP_SET;
			else if (pick < 60) op = OP_CLEAR;
			else if (pick < 95) op = OP_QUERY;
			else op = OP_UNUSED;
			if ($urandom_range(0, 9) == 0) begin
				x = $urandom_range(0, MAP_DIM - 1);
				y = $urandom_range(0, MAP_DIM - 1);
			end else begin
				x = clip_coord(cx + $urandom_range(0, 16) - 8, w);
				y = clip_coord(cy + $urandom_range(0, 16) - 8, h);
			end
			put_random(op, x, y);
			if (op != OP_UNUSED && x < w && y < h) done++;
		end
		quiet = 1'b0;
	endtask

	initial begin
		int xi, yi;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty window, rounding, map edges, window borders
		put(OP_QUERY, 5, 5, 0, 0, 0, 63, 0, 63);
		put(OP_SET, 0, 0, 255, 0, 255, 0, 0, 0);
		put(OP_SET, 1, 1, 1, 254, 128, 63, 63, 63);
		put(OP_QUERY, 0, 0, 0, 0, 0, 21, 42, 7);
		put(OP_SET, 127, 127, 255, 255, 255, 0, 0, 0);
		put(OP_QUERY, 127, 127, 0, 0, 0, 1, 2, 3);
		put(OP_QUERY, 121, 121, 0, 0, 0, 0, 0, 0);
		put(OP_QUERY, 120, 120, 0, 0, 0, 63, 63, 63);
		put(OP_CLEAR, 127, 127, 255, 255, 255, 63, 63, 63);
		put(OP_QUERY, 127, 127, 0, 0, 0, 0, 0, 0);
		// unused op code changes nothing
		put(OP_UNUSED, 3, 3, 9, 9, 9, 9, 9, 9);
		put(OP_QUERY, 0, 0, 0, 0, 0, 5, 5, 5);
		put(OP_SET, 6, 6, 10, 20, 30, 0, 0, 0);
		put(OP_QUERY, 12, 12, 0, 0, 0, 0, 0, 0);
		put(OP_QUERY, 13, 13, 0, 0, 0, 33, 44, 55);
		put(OP_SET, 0, 127, 7, 8, 9, 0, 0, 0);
		put(OP_QUERY, 0, 127, 0, 0, 0, 0, 0, 0);

		// zero width held at one, height above the maximum held at the maximum
		set_map(0, 255);
		put(OP_SET, 1, 0, 200, 200, 200, 0, 0, 0);
		put(OP_QUERY, 0, 5, 0, 0, 0, 0, 0, 0);
		put(OP_QUERY, 0, 127, 0, 0, 0, 0, 0, 0);
		put(OP_QUERY, 1, 1, 0, 0, 0, 0, 0, 0);
		set_map(128, 1);
		put(OP_QUERY, 6, 0, 0, 0, 0, 0, 0, 0);
		put(OP_QUERY, 5, 1, 0, 0, 0, 0, 0, 0);
		// pixels hidden by a smaller map come back when it grows
		set_map(128, 128);
		put(OP_QUERY, 1, 1, 0, 0, 0, 0, 0, 0);

		// full window: every pixel of a 13 by 13 block set
		for (xi = 40; xi <= 52; xi++) begin
			for (yi = 40; yi <= 52; yi++) begin
				put_random(OP_SET, xi, yi);
			end
		end
		put_random(OP_QUERY, 46, 46);
		put_random(OP_QUERY, 40, 52);
		put_random(OP_CLEAR, 46, 46);
		put_random(OP_QUERY, 46, 46);

		run_phase(128, 128, 70);
		run_phase(0, 0, 30);
		run_phase(255, 200, 80);
		run_phase(1, 128, 70);
		run_phase(128, 1, 70);
		run_phase(20, 13, 80);
		run_phase(64, 100, 80);
		run_phase($urandom_range(1, 128), $urandom_range(1, 128), 80);

		drain();
		if (board.failures == 0 && board.waiting() == 0) begin
			$display("set_neighbor_window_average_tb passed");
		end else begin
			$display("set_neighbor_window_average_tb failed");
		end
		$finish;
	end

endmodule
